### rtl/core/khc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_pkg
// Shared sizes, command codes and controller/datapath interface types for the
// keyed handle cache.
// ----------------------------------------------------------------------------
package khc_pkg;

  localparam int ENTRIES     = 8;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int AGE_BITS    = 32;
  localparam int CMD_BITS    = 2;
  localparam int FREED_BITS  = 4;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int IN_BITS  = CMD_BITS + KEY_BITS + HANDLE_BITS;
  localparam int OUT_BITS = 1 + HANDLE_BITS + 1 + HANDLE_BITS + FREED_BITS;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [FREED_BITS-1:0] FREED_MAX = '1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TAKE    = 2'd0,
    CMD_PUT     = 2'd1,
    CMD_INV_KEY = 2'd2,
    CMD_INV_ALL = 2'd3
  } cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;  // capture a new item, restart the scan
    logic step;       // examine the entry at the scan index
    logic store;      // write the put entry
    logic load_out;   // copy the result into the output register
  } dp_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;    // scan may end at the current entry
    logic last;    // scan index is on the final entry
    logic is_put;  // current item is a put
  } dp_stat_t;

endpackage

### rtl/core/keyed_handle_cache_oldest_evict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_handle_cache_oldest_evict
// Fully associative keyed handle pool with oldest-entry replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ channel, one transfer per command; each gives
//   exactly one result transfer on the m_ channel.
//   Take returns and frees the lowest matching entry, put fills the lowest
//   free entry or replaces the oldest one, invalidate-key and invalidate-all
//   free entries and report the count.
//   The entries are walked one per cycle; a put then takes a store step
//   before its result, and a take hit or a put finding a free entry ends the
//   walk early. One command is in flight at a time, so the command rate is
//   set by this walk over the entry registers.
//   The result sits in an output register: s_tready rises again as soon as the
//   result is loaded, even while m_tready is low. A stalled receiver holds the
//   block in its final state until the output register is free.
//   Reset empties every entry and clears the age counter.
// ----------------------------------------------------------------------------
module keyed_handle_cache_oldest_evict
  import khc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], key[33:2], handle[49:34]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // hit[0], handle_out[16:1], evicted[17],
                                      // evicted_handle[33:18], freed_count[37:34]
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencer: handshakes and scan control
  khc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Entries, scan state and result/output registers
  khc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .s_tdata (s_tdata),
    .m_tdata (m_tdata)
  );

endmodule

### rtl/core/khc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_ctrl
// Sequencer: accepts one item, walks the entries, stores a put and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module khc_ctrl
  import khc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STORE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    ctrl           = '0;
    ctrl.load_item = (state == ST_IDLE) && s_tvalid;
    ctrl.step      = (state == ST_SCAN);
    ctrl.store     = (state == ST_STORE);
    ctrl.load_out  = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drop valid once taken, unless a new result replaces it this cycle
      if (m_tready && !ctrl.load_out) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.stop || stat.last) begin
            state <= stat.is_put ? ST_STORE : ST_FINISH;
          end
        end
        ST_STORE: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/khc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_dp
// Entry storage, scan index, result registers and output register.
// ----------------------------------------------------------------------------
module khc_dp
  import khc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_ctrl_t         ctrl,
  output dp_stat_t         stat,
  input  logic [IN_W-1:0]  s_tdata,
  output logic [OUT_W-1:0] m_tdata
);

  logic                   valid_q  [ENTRIES];
  logic [KEY_BITS-1:0]    key_q    [ENTRIES];
  logic [HANDLE_BITS-1:0] handle_q [ENTRIES];
  logic [AGE_BITS-1:0]    age_q    [ENTRIES];
  logic [AGE_BITS-1:0]    age_counter;

  cmd_t                   cmd;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] hnd;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       slot;
  logic                   free_found;
  logic [AGE_BITS-1:0]    min_age;
  logic [HANDLE_BITS-1:0] oldest_handle;

  logic                   hit;
  logic [HANDLE_BITS-1:0] hout;
  logic                   ev;
  logic [HANDLE_BITS-1:0] evh;
  logic [FREED_BITS-1:0]  freed;

  logic cur_valid, cur_match, take_hit, put_free, put_older, inv_hit, last;

  assign cur_valid = valid_q[idx];
  assign cur_match = cur_valid && (key_q[idx] == key);
  assign take_hit  = (cmd == CMD_TAKE) && cur_match;
  assign put_free  = (cmd == CMD_PUT) && !cur_valid;
  assign put_older = (cmd == CMD_PUT) && cur_valid
                     && ((idx == '0) || (min_age > age_q[idx]));
  assign inv_hit   = ((cmd == CMD_INV_ALL) && cur_valid)
                     || ((cmd == CMD_INV_KEY) && cur_match);
  assign last      = (idx == IDX_W'(ENTRIES - 1));

  assign stat.stop   = take_hit || put_free;
  assign stat.last   = last;
  assign stat.is_put = (cmd == CMD_PUT);

  // Valid bits and age counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
      age_counter <= '0;
    end else begin
      if (ctrl.step && (take_hit || inv_hit)) begin
        valid_q[idx] <= 1'b0;
      end
      if (ctrl.store) begin
        valid_q[slot] <= 1'b1;
        age_counter   <= age_counter + 1'b1;
      end
    end
  end

  // Entry payload; only read where the valid bit is set
  always_ff @(posedge clk) begin
    if (ctrl.store) begin
      key_q[slot]    <= key;
      handle_q[slot] <= hnd;
      age_q[slot]    <= age_counter + 1'b1;
    end
  end

  // Item capture, scan and result registers
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd        <= cmd_t'(s_tdata[CMD_BITS-1:0]);
      key        <= s_tdata[CMD_BITS +: KEY_BITS];
      hnd        <= s_tdata[CMD_BITS+KEY_BITS +: HANDLE_BITS];
      idx        <= '0;
      slot       <= '0;
      free_found <= 1'b0;
      hit        <= 1'b0;
      hout       <= '0;
      ev         <= 1'b0;
      evh        <= '0;
      freed      <= '0;
    end
    if (ctrl.step) begin
      if (!last) begin
        idx <= idx + 1'b1;
      end
      if (take_hit) begin
        hit  <= 1'b1;
        hout <= handle_q[idx];
      end
      if (put_free) begin
        slot       <= idx;
        free_found <= 1'b1;
      end else if (put_older) begin
        slot          <= idx;
        min_age       <= age_q[idx];
        oldest_handle <= handle_q[idx];
      end
      if (inv_hit && (freed != FREED_MAX)) begin
        freed <= freed + 1'b1;
      end
    end
    if (ctrl.store && !free_found) begin
      ev  <= 1'b1;
      evh <= oldest_handle;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      m_tdata <= OUT_W'({freed, evh, ev, hout, hit});
    end
  end

endmodule
